### rtl/fftbr_pkg.sv
`timescale 1ns / 1ps
package fftbr_pkg;

   localparam int LOG2_MAX_POINTS = 10;
   localparam int SAMPLE_BITS     = 16;
   localparam int MAX_POINTS      = 1 << LOG2_MAX_POINTS;
   localparam int ADDR_BITS       = LOG2_MAX_POINTS + 1;
   localparam int LOG2_BITS       = $clog2(LOG2_MAX_POINTS + 1);
   localparam int CSR_INDEX_BITS  = 1;
   localparam int CSR_DATA_BITS   = 4;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LOG2_POINTS   = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INVERSE_SCALE = 1'd1;

   localparam logic [3:0] LOG2_POINTS_RESET = 4'd10;

   typedef logic [LOG2_MAX_POINTS-1:0] index_type;

   // Scaling control that travels with a read beat.
   typedef struct packed {
      logic                 enable;
      logic [LOG2_BITS-1:0] shift;
   } scale_ctrl_type;

   // Reverse the low num_bits bits of an index; upper bits come out zero.
   function automatic index_type reverse_index_bits(input index_type value,
                                                    input logic [LOG2_BITS-1:0] num_bits);
      index_type result;
      result = '0;
      for (int k = 0; k < LOG2_MAX_POINTS; k++) begin
         if (k < int'(num_bits)) begin
            result[k] = value[LOG2_BITS'(int'(num_bits) - 1 - k)];
         end
      end
      return result;
   endfunction

endpackage

### rtl/fftbr_scaler.sv
`timescale 1ns / 1ps
module fftbr_scaler import fftbr_pkg::*; (
   input  logic [SAMPLE_BITS-1:0] raw_real,
   input  logic [SAMPLE_BITS-1:0] raw_imag,
   input  scale_ctrl_type         ctrl,
   output logic [SAMPLE_BITS-1:0] scaled_real,
   output logic [SAMPLE_BITS-1:0] scaled_imag
);

   // Divide by N as an arithmetic shift, which rounds toward minus infinity.
   always_comb begin
      if (ctrl.enable) begin
         scaled_real = $signed(raw_real) >>> ctrl.shift;
         scaled_imag = $signed(raw_imag) >>> ctrl.shift;
      end else begin
         scaled_real = raw_real;
         scaled_imag = raw_imag;
      end
   end

endmodule

### rtl/fft_bit_reversal_reorder.sv
`timescale 1ns / 1ps
// Bit-reversal reorder buffer with a two-bank sample memory.
// A result is registered from memory into the read register, then into the output register.
// Throughput: one beat per cycle unless stalled; each beat writes memory, and reads it once a frame is ready.
// Output appears from the second frame on, one frame behind the input.
// Reset (synchronous) clears counters, bank select and pipeline; memory is not cleared.
module fft_bit_reversal_reorder import fftbr_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_wdata,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_real,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_imag,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_out_real,
   output logic signed [SAMPLE_BITS-1:0] rsp_out_imag,
   output logic [LOG2_MAX_POINTS-1:0]    rsp_out_position,
   output logic                          rsp_frame_end
);

   logic [3:0]                   log2_points_ff;
   logic                         inverse_scale_ff;
   index_type                    write_count_ff, write_count_in;
   logic                         write_bank_ff, write_bank_in;
   logic                         frame_ready_ff, frame_ready_in;

   logic [2*SAMPLE_BITS-1:0]     store [0:2*MAX_POINTS-1];
   logic [2*SAMPLE_BITS-1:0]     rd_data_ff;
   logic                         s1_valid_ff, s1_valid_in;
   index_type                    s1_position_ff;
   logic                         s1_frame_end_ff;
   scale_ctrl_type               s1_ctrl_ff;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0]       rsp_real_ff, rsp_imag_ff;
   index_type                    rsp_position_ff;
   logic                         rsp_frame_end_ff;

   logic [LOG2_BITS-1:0]         eff_log2;
   index_type                    point_mask;
   index_type                    wr_index;
   index_type                    rd_index;
   logic                         last_beat;
   logic                         req_accept;
   logic                         rd_issue;
   logic                         s1_advance;
   logic [SAMPLE_BITS-1:0]       scaled_real, scaled_imag;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         log2_points_ff   <= LOG2_POINTS_RESET;
         inverse_scale_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_LOG2_POINTS:   log2_points_ff   <= csr_wdata;
            CSR_INVERSE_SCALE: inverse_scale_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Effective frame size, clamped to the supported range.
   always_comb begin
      if (log2_points_ff == 4'd0) begin
         eff_log2 = LOG2_BITS'(1);
      end else if (int'(log2_points_ff) > LOG2_MAX_POINTS) begin
         eff_log2 = LOG2_BITS'(LOG2_MAX_POINTS);
      end else begin
         eff_log2 = LOG2_BITS'(log2_points_ff);
      end
      for (int k = 0; k < LOG2_MAX_POINTS; k++) begin
         point_mask[k] = (k < int'(eff_log2));
      end
   end

   assign wr_index  = write_count_ff & point_mask;
   assign rd_index  = reverse_index_bits(wr_index, eff_log2);
   assign last_beat = (write_count_ff >= point_mask);

   // Handshake: hold off the input while the read stage cannot move on.
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_advance;
   assign req_accept = req_valid && !req_stall;
   assign rd_issue   = req_accept && frame_ready_ff;

   // Frame counter and bank select.
   always_comb begin
      write_count_in = write_count_ff;
      write_bank_in  = write_bank_ff;
      frame_ready_in = frame_ready_ff;
      if (req_accept) begin
         if (last_beat) begin
            write_count_in = '0;
            write_bank_in  = !write_bank_ff;
            frame_ready_in = 1'b1;
         end else begin
            write_count_in = write_count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_count_ff <= '0;
         write_bank_ff  <= 1'b0;
         frame_ready_ff <= 1'b0;
      end else begin
         write_count_ff <= write_count_in;
         write_bank_ff  <= write_bank_in;
         frame_ready_ff <= frame_ready_in;
      end
   end

   // Sample memory: write the current bank, read the other one. The two
   // accesses of one beat never meet the same entry.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         store[{write_bank_ff, wr_index}] <= {req_sample_real, req_sample_imag};
      end
      if (rd_issue) begin
         rd_data_ff <= store[{!write_bank_ff, rd_index}];
      end
   end

   // Read stage bookkeeping that travels alongside the memory data.
   always_comb begin
      if (rd_issue) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_issue) begin
         s1_position_ff    <= wr_index;
         s1_frame_end_ff   <= last_beat;
         s1_ctrl_ff.enable <= inverse_scale_ff;
         s1_ctrl_ff.shift  <= eff_log2;
      end
   end

   fftbr_scaler u_scaler (
      .raw_real    (rd_data_ff[2*SAMPLE_BITS-1:SAMPLE_BITS]),
      .raw_imag    (rd_data_ff[SAMPLE_BITS-1:0]),
      .ctrl        (s1_ctrl_ff),
      .scaled_real (scaled_real),
      .scaled_imag (scaled_imag)
   );

   // Output register.
   always_comb begin
      if (s1_advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_real_ff      <= scaled_real;
         rsp_imag_ff      <= scaled_imag;
         rsp_position_ff  <= s1_position_ff;
         rsp_frame_end_ff <= s1_frame_end_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_real     = rsp_real_ff;
   assign rsp_out_imag     = rsp_imag_ff;
   assign rsp_out_position = rsp_position_ff;
   assign rsp_frame_end    = rsp_frame_end_ff;

endmodule
